// File: rtl/core/oat_pkg.sv
// Package for the ordered array table engine: shared types, operation codes,
// status codes, cell select codes and controller state codes.
// No dependencies.
`default_nettype none

package oat_pkg;

  localparam int ELEM_W = 32;

  typedef logic [2:0] mode_t;
  typedef logic [2:0] status_t;
  typedef logic [2:0] cell_sel_t;
  typedef logic [2:0] state_t;
  typedef logic signed [ELEM_W-1:0] elem_t;

  localparam mode_t MODE_CLEAR   = 3'd0;
  localparam mode_t MODE_APPEND  = 3'd1;
  localparam mode_t MODE_INSERT  = 3'd2;
  localparam mode_t MODE_DELETE  = 3'd3;
  localparam mode_t MODE_SEARCH  = 3'd4;
  localparam mode_t MODE_REVERSE = 3'd5;
  localparam mode_t MODE_DUMP    = 3'd6;

  localparam status_t ST_OK     = 3'd0;
  localparam status_t ST_EMPTY  = 3'd1;
  localparam status_t ST_FULL   = 3'd2;
  localparam status_t ST_BADPOS = 3'd3;
  localparam status_t ST_NOKEY  = 3'd4;

  localparam cell_sel_t SEL_HOLD  = 3'd0;
  localparam cell_sel_t SEL_LOAD  = 3'd1;
  localparam cell_sel_t SEL_LEFT  = 3'd2;
  localparam cell_sel_t SEL_RIGHT = 3'd3;
  localparam cell_sel_t SEL_HEAD  = 3'd4;

  localparam state_t S_IDLE = 3'd0;
  localparam state_t S_EXEC = 3'd1;
  localparam state_t S_FIND = 3'd2;
  localparam state_t S_INS  = 3'd3;
  localparam state_t S_REV  = 3'd4;
  localparam state_t S_DUMP = 3'd5;

endpackage

`default_nettype wire

// File: rtl/core/oat_cell.sv
// One storage cell of the element chain: holds one element, takes a new value
// from the operand, its neighbors or the head cell, and compares with the operand.
// Depends on oat_pkg.
`default_nettype none

module oat_cell (
  input  wire              clk,
  input  oat_pkg::cell_sel_t sel,
  input  oat_pkg::elem_t   op_value,
  input  oat_pkg::elem_t   left_data,
  input  oat_pkg::elem_t   right_data,
  input  oat_pkg::elem_t   head_data,
  output oat_pkg::elem_t   data,
  output logic             eq,
  output logic             gt
);
  import oat_pkg::*;

  elem_t data_r;
  elem_t data_nxt;

  always_comb begin
    case (sel)
      SEL_HOLD:  data_nxt = data_r;
      SEL_LOAD:  data_nxt = op_value;
      SEL_LEFT:  data_nxt = left_data;
      SEL_RIGHT: data_nxt = right_data;
      SEL_HEAD:  data_nxt = head_data;
      default:   data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;
  assign eq   = (data_r == op_value);
  assign gt   = (data_r > op_value);

endmodule

`default_nettype wire

// File: rtl/core/oat_ctrl.sv
// Controller of the ordered array table engine: handshakes, operation sequencing,
// fill count, per-cell select generation and the result register.
// Depends on oat_pkg.
`default_nettype none

module oat_ctrl #(
  parameter int CAPACITY = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  oat_pkg::mode_t      in_mode,
  input  oat_pkg::elem_t      in_value,
  input  wire [CNT_W-1:0]     in_position,
  output logic                out_valid,
  input  wire                 out_ready,
  output oat_pkg::status_t    out_status,
  output oat_pkg::elem_t      out_element,
  output logic [CNT_W-1:0]    out_found_position,
  output logic [CNT_W-1:0]    out_count,
  output logic                out_last,
  output oat_pkg::cell_sel_t  cell_sel [CAPACITY],
  output oat_pkg::elem_t      op_value,
  input  oat_pkg::elem_t      head_data,
  input  wire [CAPACITY-1:0]  eq_vec,
  input  wire [CAPACITY-1:0]  gt_vec
);
  import oat_pkg::*;

  state_t             state_r, state_nxt;
  mode_t              mode_r;
  elem_t              value_r;
  logic [CNT_W-1:0]   pos_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   aux_r, aux_nxt;
  logic [CAPACITY-1:0] flag_r, flag_nxt;

  logic               out_valid_r;
  status_t            out_status_r;
  elem_t              out_element_r;
  logic [CNT_W-1:0]   out_fp_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               out_last_r;

  logic               slot_ok;
  logic               full;
  logic               emit;
  status_t            res_status;
  elem_t              res_elem;
  logic [CNT_W-1:0]   res_fp;
  logic               res_last;
  logic               do_rot;
  logic [CNT_W-1:0]   rot_len;
  logic               found;
  logic [CNT_W-1:0]   found_pos;
  logic [CNT_W-1:0]   ins_pos;

  assign slot_ok  = !out_valid_r || out_ready;
  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign in_ready = (state_r == S_IDLE);
  assign op_value = value_r;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) < cnt_r) begin
        flag_nxt[i] = (mode_r == MODE_SEARCH) ? eq_vec[i] : gt_vec[i];
      end else begin
        flag_nxt[i] = (mode_r != MODE_SEARCH);
      end
    end
  end

  always_comb begin
    found     = 1'b0;
    found_pos = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (flag_r[i]) begin
        found     = 1'b1;
        found_pos = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!flag_r[i]) begin
        ins_pos = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    aux_nxt    = aux_r;
    emit       = 1'b0;
    res_status = ST_OK;
    res_elem   = '0;
    res_fp     = '0;
    res_last   = 1'b1;
    do_rot     = 1'b0;
    rot_len    = cnt_r;
    for (int i = 0; i < CAPACITY; i++) begin
      cell_sel[i] = SEL_HOLD;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_r)
          MODE_CLEAR: begin
            if (slot_ok) begin
              emit      = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_IDLE;
            end
          end
          MODE_APPEND: begin
            if (slot_ok) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (full) begin
                res_status = ST_FULL;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i) == cnt_r) begin
                    cell_sel[i] = SEL_LOAD;
                  end
                end
                cnt_nxt = cnt_r + 1'b1;
              end
            end
          end
          MODE_INSERT: begin
            if (!full) begin
              state_nxt = S_INS;
            end else if (slot_ok) begin
              emit       = 1'b1;
              res_status = ST_FULL;
              state_nxt  = S_IDLE;
            end
          end
          MODE_DELETE: begin
            if (slot_ok) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
              if (cnt_r == '0) begin
                res_status = ST_EMPTY;
              end else if (pos_r == '0 || pos_r > cnt_r) begin
                res_status = ST_BADPOS;
              end else begin
                for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i + 1) >= pos_r && CNT_W'(i + 1) < cnt_r) begin
                    cell_sel[i] = SEL_RIGHT;
                  end
                end
                cnt_nxt = cnt_r - 1'b1;
              end
            end
          end
          MODE_SEARCH: begin
            if (cnt_r != '0) begin
              state_nxt = S_FIND;
            end else if (slot_ok) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
              state_nxt  = S_IDLE;
            end
          end
          MODE_REVERSE: begin
            if (cnt_r > CNT_W'(1)) begin
              aux_nxt   = cnt_r;
              state_nxt = S_REV;
            end else if (slot_ok) begin
              emit       = 1'b1;
              res_status = (cnt_r == '0) ? ST_EMPTY : ST_OK;
              state_nxt  = S_IDLE;
            end
          end
          MODE_DUMP: begin
            if (cnt_r != '0) begin
              aux_nxt   = '0;
              state_nxt = S_DUMP;
            end else if (slot_ok) begin
              emit       = 1'b1;
              res_status = ST_EMPTY;
              state_nxt  = S_IDLE;
            end
          end
          default: begin
            if (slot_ok) begin
              emit      = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_FIND: begin
        if (slot_ok) begin
          emit       = 1'b1;
          state_nxt  = S_IDLE;
          res_status = found ? ST_OK : ST_NOKEY;
          res_fp     = found ? found_pos : '0;
        end
      end
      S_INS: begin
        if (slot_ok) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          cnt_nxt   = cnt_r + 1'b1;
          for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i) == ins_pos) begin
              cell_sel[i] = SEL_LOAD;
            end else if (CNT_W'(i) > ins_pos && CNT_W'(i) <= cnt_r) begin
              cell_sel[i] = SEL_LEFT;
            end
          end
        end
      end
      S_REV: begin
        rot_len = aux_r;
        if (aux_r > CNT_W'(2)) begin
          do_rot  = 1'b1;
          aux_nxt = aux_r - 1'b1;
        end else if (slot_ok) begin
          do_rot    = 1'b1;
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DUMP: begin
        if (slot_ok) begin
          do_rot   = 1'b1;
          emit     = 1'b1;
          res_elem = head_data;
          res_last = (aux_r == cnt_r - 1'b1);
          aux_nxt  = aux_r + 1'b1;
          if (res_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (do_rot) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (CNT_W'(i + 1) < rot_len) begin
          cell_sel[i] = SEL_RIGHT;
        end else if (CNT_W'(i + 1) == rot_len) begin
          cell_sel[i] = SEL_HEAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    aux_r  <= aux_nxt;
    flag_r <= flag_nxt;
    if (in_valid && in_ready) begin
      mode_r  <= in_mode;
      value_r <= in_value;
      pos_r   <= in_position;
    end
    if (emit) begin
      out_status_r  <= res_status;
      out_element_r <= res_elem;
      out_fp_r      <= res_fp;
      out_count_r   <= cnt_nxt;
      out_last_r    <= res_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_element        = out_element_r;
  assign out_found_position = out_fp_r;
  assign out_count          = out_count_r;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/ordered_array_table_engine_unit.sv
// Ordered array table engine: a chain of CAPACITY element cells under one
// controller. Every operation takes one transaction and answers with one result,
// except dump, which gives one result per stored element with out_last on the
// final one. After a transaction is accepted, clear, append, delete and the
// unused mode answer straight from the execute state; search and ordered
// insert first register the per-cell compare flags, then encode them; reverse
// and dump of n stored elements step the chain through prefix rotations, one
// rotation per cycle while the result channel does not stall.
// Full-table inserts, empty searches and dumps, and reverses of fewer than two
// elements answer straight from the execute state.
// A stalled result channel holds the engine only where a result is due.
// Depends on oat_pkg, oat_cell and oat_ctrl.
`default_nettype none

module ordered_array_table_engine_unit #(
  parameter int CAPACITY = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  oat_pkg::mode_t    in_mode,
  input  oat_pkg::elem_t    in_value,
  input  wire [CNT_W-1:0]   in_position,
  output logic              out_valid,
  input  wire               out_ready,
  output oat_pkg::status_t  out_status,
  output oat_pkg::elem_t    out_element,
  output logic [CNT_W-1:0]  out_found_position,
  output logic [CNT_W-1:0]  out_count,
  output logic              out_last
);
  import oat_pkg::*;

  cell_sel_t           cell_sel [CAPACITY];
  elem_t               cell_data [CAPACITY];
  elem_t               op_value;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] gt_vec;

  oat_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_element        (out_element),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .out_last           (out_last),
    .cell_sel           (cell_sel),
    .op_value           (op_value),
    .head_data          (cell_data[0]),
    .eq_vec             (eq_vec),
    .gt_vec             (gt_vec)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    elem_t left_in;
    elem_t right_in;

    if (g == 0) begin : g_first
      assign left_in = op_value;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_in = op_value;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end

    oat_cell u_cell (
      .clk        (clk),
      .sel        (cell_sel[g]),
      .op_value   (op_value),
      .left_data  (left_in),
      .right_data (right_in),
      .head_data  (cell_data[0]),
      .data       (cell_data[g]),
      .eq         (eq_vec[g]),
      .gt         (gt_vec[g])
    );
  end

endmodule

`default_nettype wire
